// ===== rtl/core/complex_arithmetic_unit_assert.svh =====
// Assertion macros shared by the complex arithmetic unit RTL.
// The macros expect signals named clk and rst_n in the enclosing module.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAU_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cau_pkg.sv =====
// Package for the complex arithmetic unit: operation codes and the control
// bundle that travels down the pipeline. No dependencies.
`default_nettype none

package cau_pkg;

  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MAG = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic              neg_x;
    logic              neg_y;
  } cau_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cau_front.sv =====
// Front end of the complex arithmetic unit: add/subtract, the six products,
// the cross sums, sign split and multiply rounding. Depends on cau_pkg.
`default_nettype none

module cau_front import cau_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic [KIND_W-1:0]             in_kind,
  input  logic signed [DATA_WIDTH-1:0]  a_re,
  input  logic signed [DATA_WIDTH-1:0]  a_im,
  input  logic signed [DATA_WIDTH-1:0]  b_re,
  input  logic signed [DATA_WIDTH-1:0]  b_im,
  output cau_ctl_t                      ctl_o,
  output logic [2*DATA_WIDTH-1:0]       num_x_o,
  output logic [2*DATA_WIDTH-1:0]       num_y_o,
  output logic [2*DATA_WIDTH-1:0]       dsum_o,
  output logic [DATA_WIDTH-1:0]         dre_o,
  output logic [DATA_WIDTH-1:0]         dim_o,
  output logic                          dovf_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam logic [PW:0] HALF = ((PW+1)'(1) << FRAC_BITS) >> 1;
  localparam logic [PW:0] LIM  = (PW+1)'(1) << (W-1);
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // Saturate a sum that is two bits wider than the result; {ovf, value}.
  function automatic logic [W:0] sat_add(input logic signed [W+1:0] s);
    logic         ovf;
    logic [W-1:0] v;
    ovf = (s[W+1] != s[W]) || (s[W] != s[W-1]);
    if (!ovf) v = s[W-1:0];
    else if (s[W+1]) v = MIN_V;
    else v = MAX_V;
    return {ovf, v};
  endfunction

  // Saturate a sign and magnitude pair; {ovf, value}.
  function automatic logic [W:0] sat_mag(input logic neg, input logic [PW:0] q);
    logic         ovf;
    logic [W-1:0] v;
    if (neg) begin
      ovf = q > LIM;
      v   = ovf ? MIN_V : (~q[W-1:0] + 1'b1);
    end else begin
      ovf = q >= LIM;
      v   = ovf ? MAX_V : q[W-1:0];
    end
    return {ovf, v};
  endfunction

  logic [4:0] v_r;

  // Stage 0
  logic [KIND_W-1:0]       k0_r;
  logic signed [W-1:0]     ar0_r, ai0_r, br0_r, bi0_r;
  logic [W-1:0]            dre0_r, dim0_r;
  logic                    dovf0_r;
  logic signed [W+1:0]     sum_re, sum_im;
  logic [W:0]              sat_re, sat_im;

  // Stage 1
  logic [KIND_W-1:0]       k1_r;
  logic signed [PW-1:0]    p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [W-1:0]     u4, u5;
  logic [W-1:0]            dre1_r, dim1_r;
  logic                    dovf1_r;

  // Stage 2
  logic [KIND_W-1:0]       k2_r;
  logic signed [PW:0]      x2_r, y2_r;
  logic [PW-1:0]           d2_r;
  logic [W-1:0]            dre2_r, dim2_r;
  logic                    dovf2_r;

  // Stage 3
  logic [KIND_W-1:0]       k3_r;
  logic                    nx3_r, ny3_r;
  logic [PW-1:0]           mx3_r, my3_r, d3_r;
  logic [W-1:0]            dre3_r, dim3_r;
  logic                    dovf3_r;
  logic [PW:0]             rnd_x, rnd_y;
  logic [W:0]              mul_re, mul_im;

  // Stage 4
  logic [KIND_W-1:0]       k4_r;
  logic                    nx4_r, ny4_r;
  logic [PW-1:0]           mx4_r, my4_r, d4_r;
  logic [W-1:0]            dre4_r, dim4_r;
  logic                    dovf4_r;

  always_comb begin
    if (in_kind == KIND_SUB) begin
      sum_re = (W+2)'(a_re) - (W+2)'(b_re);
      sum_im = (W+2)'(a_im) - (W+2)'(b_im);
    end else begin
      sum_re = (W+2)'(a_re) + (W+2)'(b_re);
      sum_im = (W+2)'(a_im) + (W+2)'(b_im);
    end
    sat_re = sat_add(sum_re);
    sat_im = sat_add(sum_im);
  end

  // Magnitude squares a; the divisor norm squares b.
  always_comb begin
    u4 = (k0_r == KIND_MAG) ? ar0_r : br0_r;
    u5 = (k0_r == KIND_MAG) ? ai0_r : bi0_r;
  end

  always_comb begin
    rnd_x  = ({1'b0, mx3_r} + HALF) >> FRAC_BITS;
    rnd_y  = ({1'b0, my3_r} + HALF) >> FRAC_BITS;
    mul_re = sat_mag(nx3_r, rnd_x);
    mul_im = sat_mag(ny3_r, rnd_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      k0_r    <= in_kind;
      ar0_r   <= a_re;
      ai0_r   <= a_im;
      br0_r   <= b_re;
      bi0_r   <= b_im;
      dre0_r  <= sat_re[W-1:0];
      dim0_r  <= sat_im[W-1:0];
      dovf0_r <= sat_re[W] | sat_im[W];

      k1_r    <= k0_r;
      p0_r    <= ar0_r * br0_r;
      p1_r    <= ai0_r * bi0_r;
      p2_r    <= ar0_r * bi0_r;
      p3_r    <= ai0_r * br0_r;
      p4_r    <= u4 * u4;
      p5_r    <= u5 * u5;
      dre1_r  <= dre0_r;
      dim1_r  <= dim0_r;
      dovf1_r <= dovf0_r;

      k2_r <= k1_r;
      if (k1_r == KIND_MUL) begin
        x2_r <= (PW+1)'(p0_r) - (PW+1)'(p1_r);
        y2_r <= (PW+1)'(p2_r) + (PW+1)'(p3_r);
      end else begin
        x2_r <= (PW+1)'(p0_r) + (PW+1)'(p1_r);
        y2_r <= (PW+1)'(p3_r) - (PW+1)'(p2_r);
      end
      d2_r    <= $unsigned(p4_r) + $unsigned(p5_r);
      dre2_r  <= dre1_r;
      dim2_r  <= dim1_r;
      dovf2_r <= dovf1_r;

      k3_r    <= k2_r;
      nx3_r   <= x2_r[PW];
      ny3_r   <= y2_r[PW];
      mx3_r   <= x2_r[PW] ? PW'(-x2_r) : x2_r[PW-1:0];
      my3_r   <= y2_r[PW] ? PW'(-y2_r) : y2_r[PW-1:0];
      d3_r    <= d2_r;
      dre3_r  <= dre2_r;
      dim3_r  <= dim2_r;
      dovf3_r <= dovf2_r;

      k4_r  <= k3_r;
      nx4_r <= nx3_r;
      ny4_r <= ny3_r;
      mx4_r <= mx3_r;
      my4_r <= my3_r;
      d4_r  <= d3_r;
      if (k3_r == KIND_MUL) begin
        dre4_r  <= mul_re[W-1:0];
        dim4_r  <= mul_im[W-1:0];
        dovf4_r <= mul_re[W] | mul_im[W];
      end else begin
        dre4_r  <= dre3_r;
        dim4_r  <= dim3_r;
        dovf4_r <= dovf3_r;
      end
    end
  end

  assign ctl_o   = '{valid: v_r[4], kind: k4_r, neg_x: nx4_r, neg_y: ny4_r};
  assign num_x_o = mx4_r;
  assign num_y_o = my4_r;
  assign dsum_o  = d4_r;
  assign dre_o   = dre4_r;
  assign dim_o   = dim4_r;
  assign dovf_o  = dovf4_r;

endmodule

`default_nettype wire

// ===== rtl/core/cau_cell.sv =====
// One cell of the divide/root chain: a restoring divide step on each of the
// two quotient lanes and, in the first cells, one digit of the square root.
// Depends on cau_pkg.
`default_nettype none

module cau_cell import cau_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int STEP       = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ce,
  input  cau_ctl_t                  ctl_i,
  input  logic [2*DATA_WIDTH-1:0]   num_x_i,
  input  logic [2*DATA_WIDTH-1:0]   num_y_i,
  input  logic [2*DATA_WIDTH-1:0]   dsum_i,
  input  logic [2*DATA_WIDTH-1:0]   rem_x_i,
  input  logic [2*DATA_WIDTH-1:0]   rem_y_i,
  input  logic [DATA_WIDTH-1:0]     quo_x_i,
  input  logic [DATA_WIDTH-1:0]     quo_y_i,
  input  logic                      big_x_i,
  input  logic                      big_y_i,
  input  logic [DATA_WIDTH+1:0]     srem_i,
  input  logic [DATA_WIDTH-1:0]     root_i,
  input  logic [DATA_WIDTH-1:0]     dre_i,
  input  logic [DATA_WIDTH-1:0]     dim_i,
  input  logic                      dovf_i,
  output cau_ctl_t                  ctl_o,
  output logic [2*DATA_WIDTH-1:0]   num_x_o,
  output logic [2*DATA_WIDTH-1:0]   num_y_o,
  output logic [2*DATA_WIDTH-1:0]   dsum_o,
  output logic [2*DATA_WIDTH-1:0]   rem_x_o,
  output logic [2*DATA_WIDTH-1:0]   rem_y_o,
  output logic [DATA_WIDTH-1:0]     quo_x_o,
  output logic [DATA_WIDTH-1:0]     quo_y_o,
  output logic                      big_x_o,
  output logic                      big_y_o,
  output logic [DATA_WIDTH+1:0]     srem_o,
  output logic [DATA_WIDTH-1:0]     root_o,
  output logic [DATA_WIDTH-1:0]     dre_o,
  output logic [DATA_WIDTH-1:0]     dim_o,
  output logic                      dovf_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;

  // One restoring step; returns {big, quotient, remainder}.
  function automatic logic [PW+W:0] div_step(input logic [PW-1:0] rem,
                                             input logic nbit,
                                             input logic [PW-1:0] d,
                                             input logic [W-1:0] q,
                                             input logic big);
    logic [PW:0] sh;
    logic [PW:0] df;
    logic        ge;
    sh = {rem, nbit};
    ge = sh >= {1'b0, d};
    df = sh - {1'b0, d};
    return {big | q[W-1], q[W-2:0], ge, ge ? df[PW-1:0] : sh[PW-1:0]};
  endfunction

  logic            nbit_x, nbit_y;
  logic [PW+W:0]   step_x, step_y;
  logic [W+1:0]    srem_nxt;
  logic [W-1:0]    root_nxt;

  logic              valid_r;
  logic [KIND_W-1:0] kind_r;
  logic              neg_x_r, neg_y_r;
  logic [PW-1:0]     num_x_r, num_y_r, dsum_r, rem_x_r, rem_y_r;
  logic [W-1:0]      quo_x_r, quo_y_r, root_r, dre_r, dim_r;
  logic              big_x_r, big_y_r, dovf_r;
  logic [W+1:0]      srem_r;

  // Dividend bits go in from the top; after them the fraction shifts in zeros.
  if (STEP < PW) begin : g_nbit
    assign nbit_x = num_x_i[PW-1-STEP];
    assign nbit_y = num_y_i[PW-1-STEP];
  end else begin : g_nbit_zero
    assign nbit_x = 1'b0;
    assign nbit_y = 1'b0;
  end

  assign step_x = div_step(rem_x_i, nbit_x, dsum_i, quo_x_i, big_x_i);
  assign step_y = div_step(rem_y_i, nbit_y, dsum_i, quo_y_i, big_y_i);

  if (STEP < W) begin : g_sqrt
    logic [W+3:0] r4;
    logic [W+3:0] tr;
    logic [W+3:0] sd;
    logic         ge;
    always_comb begin
      r4       = {srem_i, dsum_i[PW-1-2*STEP -: 2]};
      tr       = {2'b00, root_i, 2'b01};
      ge       = r4 >= tr;
      sd       = r4 - tr;
      srem_nxt = ge ? sd[W+1:0] : r4[W+1:0];
      root_nxt = {root_i[W-2:0], ge};
    end
  end else begin : g_sqrt_pass
    assign srem_nxt = srem_i;
    assign root_nxt = root_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      kind_r      <= ctl_i.kind;
      neg_x_r     <= ctl_i.neg_x;
      neg_y_r     <= ctl_i.neg_y;
      num_x_r     <= num_x_i;
      num_y_r     <= num_y_i;
      dsum_r      <= dsum_i;
      {big_x_r, quo_x_r, rem_x_r} <= step_x;
      {big_y_r, quo_y_r, rem_y_r} <= step_y;
      srem_r      <= srem_nxt;
      root_r      <= root_nxt;
      dre_r       <= dre_i;
      dim_r       <= dim_i;
      dovf_r      <= dovf_i;
    end
  end

  assign ctl_o   = '{valid: valid_r, kind: kind_r, neg_x: neg_x_r, neg_y: neg_y_r};
  assign num_x_o = num_x_r;
  assign num_y_o = num_y_r;
  assign dsum_o  = dsum_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign quo_x_o = quo_x_r;
  assign quo_y_o = quo_y_r;
  assign big_x_o = big_x_r;
  assign big_y_o = big_y_r;
  assign srem_o  = srem_r;
  assign root_o  = root_r;
  assign dre_o   = dre_r;
  assign dim_o   = dim_r;
  assign dovf_o  = dovf_r;

endmodule

`default_nettype wire

// ===== rtl/core/cau_final.sv =====
// Last stage of the complex arithmetic unit: quotient and root rounding,
// saturation and result selection by operation. Depends on cau_pkg.
`default_nettype none

module cau_final import cau_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      ce,
  input  cau_ctl_t                  ctl_i,
  input  logic [2*DATA_WIDTH-1:0]   dsum_i,
  input  logic [2*DATA_WIDTH-1:0]   rem_x_i,
  input  logic [2*DATA_WIDTH-1:0]   rem_y_i,
  input  logic [DATA_WIDTH-1:0]     quo_x_i,
  input  logic [DATA_WIDTH-1:0]     quo_y_i,
  input  logic                      big_x_i,
  input  logic                      big_y_i,
  input  logic [DATA_WIDTH+1:0]     srem_i,
  input  logic [DATA_WIDTH-1:0]     root_i,
  input  logic [DATA_WIDTH-1:0]     dre_i,
  input  logic [DATA_WIDTH-1:0]     dim_i,
  input  logic                      dovf_i,
  output logic                      valid_o,
  output logic [2*DATA_WIDTH+1:0]   res_o     // {overflow, div_zero, im, re}
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam logic [W-1:0] LIM   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // Round a quotient lane to nearest and saturate; {ovf, value}.
  function automatic logic [W:0] quo_round(input logic neg, input logic [PW-1:0] rem,
                                           input logic [PW-1:0] d, input logic [W-1:0] q,
                                           input logic big);
    logic         up;
    logic [W:0]   q1;
    logic         huge;
    logic         ovf;
    logic [W-1:0] v;
    up   = {rem, 1'b0} >= {1'b0, d};
    q1   = {1'b0, q} + {{W{1'b0}}, up};
    huge = big | q1[W];
    if (neg) begin
      ovf = huge || (q1[W-1:0] > LIM);
      v   = ovf ? MIN_V : (~q1[W-1:0] + 1'b1);
    end else begin
      ovf = huge || q1[W-1];
      v   = ovf ? MAX_V : q1[W-1:0];
    end
    return {ovf, v};
  endfunction

  logic [W:0]      div_re, div_im;
  logic            root_up;
  logic [W:0]      root1;
  logic            mag_ovf;
  logic            dz;
  logic [PW+1:0]   res_nxt;

  logic            valid_r;
  logic [PW+1:0]   res_r;

  always_comb begin
    div_re  = quo_round(ctl_i.neg_x, rem_x_i, dsum_i, quo_x_i, big_x_i);
    div_im  = quo_round(ctl_i.neg_y, rem_y_i, dsum_i, quo_y_i, big_y_i);
    // The root rounds up when the remainder exceeds the root itself.
    root_up = srem_i > {2'b00, root_i};
    root1   = {1'b0, root_i} + {{W{1'b0}}, root_up};
    mag_ovf = |root1[W:W-1];
    dz      = (dsum_i == '0);

    case (ctl_i.kind)
      KIND_ADD, KIND_SUB, KIND_MUL: res_nxt = {dovf_i, 1'b0, dim_i, dre_i};
      KIND_DIV: begin
        if (dz) res_nxt = {1'b0, 1'b1, {W{1'b0}}, {W{1'b0}}};
        else res_nxt = {div_re[W] | div_im[W], 1'b0, div_im[W-1:0], div_re[W-1:0]};
      end
      KIND_MAG: res_nxt = {mag_ovf, 1'b0, {W{1'b0}}, mag_ovf ? MAX_V : root1[W-1:0]};
      default:  res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ce) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r <= res_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule

`default_nettype wire

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front end, chain of divide/root
// cells, final rounding stage and output skid register.
// Depends on cau_pkg, cau_front, cau_cell, cau_final and the assert macros.
//
//  Channel  Direction  Handshake              Payload
//  in_      slave      in_tvalid/in_tready    tdata {b_im,b_re,a_im,a_re}, tuser kind
//  out_     master     out_tvalid/out_tready  tdata {res_im,res_re}, tuser {ovf,div_zero}
//
// One transaction is accepted per clock while in_tready is high. On its way to
// out_tvalid a transaction passes through five front-end stages, one cell per
// quotient bit of the long division (which produces 2*DATA_WIDTH+FRAC_BITS bits
// from the numerator and the fraction shift), the rounding stage and the output
// register.
// Reset (rst_n low, synchronous) clears every valid bit; no clearing pass.
// When out_tready is low, the waiting result sits in the output register and
// the next one lands in the skid register; only then does in_tready drop and
// the whole pipeline freeze until the output drains.
`default_nettype none

`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // a_re, a_im, b_re, b_im from the lowest bit up, zero padded to bytes
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]      in_tdata,
  // kind
  input  logic [KIND_W-1:0]                      in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // res_re, res_im from the lowest bit up, zero padded to bytes
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      out_tdata,
  // div_zero, overflow from the lowest bit up
  output logic [1:0]                             out_tuser
);

  localparam int W     = DATA_WIDTH;
  localparam int PW    = 2 * DATA_WIDTH;
  localparam int NC    = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int OUT_W = ((2*DATA_WIDTH+7)/8)*8;

  // The pipeline moves whenever the skid register is free.
  logic ce;
  logic skid_full_r, skid_full_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [PW+1:0] out_res_r, skid_res_r;
  logic load_out, load_skid, taken;

  logic          fin_valid;
  logic [PW+1:0] fin_res;

  // Chain links; index 0 is fed by the front end, index NC feeds the last stage.
  cau_ctl_t       ctl_c   [NC+1];
  logic [PW-1:0]  nx_c    [NC+1];
  logic [PW-1:0]  ny_c    [NC+1];
  logic [PW-1:0]  ds_c    [NC+1];
  logic [PW-1:0]  rx_c    [NC+1];
  logic [PW-1:0]  ry_c    [NC+1];
  logic [W-1:0]   qx_c    [NC+1];
  logic [W-1:0]   qy_c    [NC+1];
  logic           bx_c    [NC+1];
  logic           by_c    [NC+1];
  logic [W+1:0]   sr_c    [NC+1];
  logic [W-1:0]   rt_c    [NC+1];
  logic [W-1:0]   dre_c   [NC+1];
  logic [W-1:0]   dim_c   [NC+1];
  logic           dovf_c  [NC+1];

  assign ce        = !skid_full_r;
  assign in_tready = !skid_full_r;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_tvalid & in_tready),
    .in_kind  (in_tuser),
    .a_re     (in_tdata[W-1:0]),
    .a_im     (in_tdata[2*W-1:W]),
    .b_re     (in_tdata[3*W-1:2*W]),
    .b_im     (in_tdata[4*W-1:3*W]),
    .ctl_o    (ctl_c[0]),
    .num_x_o  (nx_c[0]),
    .num_y_o  (ny_c[0]),
    .dsum_o   (ds_c[0]),
    .dre_o    (dre_c[0]),
    .dim_o    (dim_c[0]),
    .dovf_o   (dovf_c[0])
  );

  // Division and root start from an empty remainder and quotient.
  assign rx_c[0] = '0;
  assign ry_c[0] = '0;
  assign qx_c[0] = '0;
  assign qy_c[0] = '0;
  assign bx_c[0] = 1'b0;
  assign by_c[0] = 1'b0;
  assign sr_c[0] = '0;
  assign rt_c[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cau_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .STEP       (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ce      (ce),
      .ctl_i   (ctl_c[k]),
      .num_x_i (nx_c[k]),
      .num_y_i (ny_c[k]),
      .dsum_i  (ds_c[k]),
      .rem_x_i (rx_c[k]),
      .rem_y_i (ry_c[k]),
      .quo_x_i (qx_c[k]),
      .quo_y_i (qy_c[k]),
      .big_x_i (bx_c[k]),
      .big_y_i (by_c[k]),
      .srem_i  (sr_c[k]),
      .root_i  (rt_c[k]),
      .dre_i   (dre_c[k]),
      .dim_i   (dim_c[k]),
      .dovf_i  (dovf_c[k]),
      .ctl_o   (ctl_c[k+1]),
      .num_x_o (nx_c[k+1]),
      .num_y_o (ny_c[k+1]),
      .dsum_o  (ds_c[k+1]),
      .rem_x_o (rx_c[k+1]),
      .rem_y_o (ry_c[k+1]),
      .quo_x_o (qx_c[k+1]),
      .quo_y_o (qy_c[k+1]),
      .big_x_o (bx_c[k+1]),
      .big_y_o (by_c[k+1]),
      .srem_o  (sr_c[k+1]),
      .root_o  (rt_c[k+1]),
      .dre_o   (dre_c[k+1]),
      .dim_o   (dim_c[k+1]),
      .dovf_o  (dovf_c[k+1])
    );
  end

  cau_final #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .ctl_i   (ctl_c[NC]),
    .dsum_i  (ds_c[NC]),
    .rem_x_i (rx_c[NC]),
    .rem_y_i (ry_c[NC]),
    .quo_x_i (qx_c[NC]),
    .quo_y_i (qy_c[NC]),
    .big_x_i (bx_c[NC]),
    .big_y_i (by_c[NC]),
    .srem_i  (sr_c[NC]),
    .root_i  (rt_c[NC]),
    .dre_i   (dre_c[NC]),
    .dim_i   (dim_c[NC]),
    .dovf_i  (dovf_c[NC]),
    .valid_o (fin_valid),
    .res_o   (fin_res)
  );

  // Output register with a one-entry skid. While the skid holds a result the
  // pipeline is frozen, so the final stage keeps its result until it moves.
  always_comb begin
    taken         = out_valid_r & out_tready;
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    if (skid_full_r) begin
      if (taken) begin
        out_valid_nxt = 1'b1;
        skid_full_nxt = 1'b0;
        load_out      = 1'b1;
      end
    end else if (!out_valid_r || taken) begin
      out_valid_nxt = fin_valid;
      load_out      = 1'b1;
    end else if (fin_valid) begin
      skid_full_nxt = 1'b1;
      load_skid     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= skid_full_r ? skid_res_r : fin_res;
    end
    if (load_skid) begin
      skid_res_r <= fin_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_res_r[PW-1:0]);
  assign out_tuser  = out_res_r[PW+1:PW];

  // A full skid register always sits behind a valid output transaction.
  `CAU_ASSERT_HOLDS(a_skid_behind_out, skid_full_r, out_valid_r,
                    "skid register full while output register empty")

  // A divide by zero reports zero parts and no overflow.
  `CAU_ASSERT_HOLDS(a_div_zero_clean, out_valid_r && out_res_r[PW],
                    out_res_r[PW-1:0] == '0 && !out_res_r[PW+1],
                    "div_zero result carries nonzero data or overflow")

  // The skid stays occupied until the output transaction completes.
  `CAU_ASSERT_NEXT(a_skid_holds, skid_full_r && !out_tready, skid_full_r,
                   "skid register emptied while output stalled")

  // A result arriving behind a stalled output goes into the skid.
  `CAU_ASSERT_NEXT(a_skid_catches, out_valid_r && !out_tready && !skid_full_r && fin_valid,
                   skid_full_r, "result dropped behind a stalled output")

endmodule

`default_nettype wire

// ===== sim/complex_arithmetic_unit_checker.sv =====
// Checker for the complex arithmetic unit: watches both stream channels, predicts
// every result in Q16.16 and compares it with what the block delivers.
// Depends on cau_pkg for the operation codes.
`timescale 1ns / 100ps
`default_nettype none

module complex_arithmetic_unit_checker import cau_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tready,
  input  wire logic [127:0]  in_tdata,
  input  wire logic [2:0]    in_tuser,
  input  wire logic          out_tvalid,
  input  wire logic          out_tready,
  input  wire logic [63:0]   out_tdata,
  input  wire logic [1:0]    out_tuser,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct {
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        div_zero;
    logic        overflow;
  } cplx_result_t;

  cplx_result_t result_fifo[$];

  // Clamp a sign/magnitude value to 32 bits; bit 32 of the return is the overflow.
  function automatic logic [32:0] clamp_q16(input logic neg, input logic [129:0] mag);
    if (!neg) begin
      if (mag > 130'h7fff_ffff) return {1'b1, 32'h7fff_ffff};
      return {1'b0, mag[31:0]};
    end
    if (mag > 130'h8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, -mag[31:0]};
  endfunction

  // Quotient of a signed numerator by a positive denominator, scaled by 2^16 and
  // rounded to nearest with ties away from zero.
  function automatic logic [32:0] div_q16(input logic signed [129:0] num,
                                          input logic [129:0] den);
    logic [129:0] mag;
    logic [129:0] q;
    mag = num[129] ? -num : num;
    q = ((mag << 17) + den) / (den << 1);
    return clamp_q16(num[129], q);
  endfunction

  function automatic cplx_result_t compute_result(input logic [2:0] op,
                                                  input logic signed [31:0] ar,
                                                  input logic signed [31:0] ai,
                                                  input logic signed [31:0] br,
                                                  input logic signed [31:0] bi);
    cplx_result_t r;
    logic signed [129:0] x, y, d;
    logic [129:0] mx, my, s, root;
    logic [32:0] pr, pi;
    r = '{default: '0};
    pr = '0;
    pi = '0;
    case (op)
      KIND_ADD, KIND_SUB: begin
        x = (op == KIND_ADD) ? ar + br : ar - br;
        y = (op == KIND_ADD) ? ai + bi : ai - bi;
        pr = clamp_q16(x[129], x[129] ? -x : x);
        pi = clamp_q16(y[129], y[129] ? -y : y);
      end
      KIND_MUL: begin
        x = ar * br - ai * bi;
        y = ar * bi + ai * br;
        mx = x[129] ? -x : x;
        my = y[129] ? -y : y;
        pr = clamp_q16(x[129], (mx + 130'h8000) >> 16);
        pi = clamp_q16(y[129], (my + 130'h8000) >> 16);
      end
      KIND_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.div_zero = 1'b1;
        end else begin
          pr = div_q16(ar * br + ai * bi, d);
          pi = div_q16(ai * br - ar * bi, d);
        end
      end
      KIND_MAG: begin
        s = ar * ar + ai * ai;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
          if ((root | (130'd1 << b)) * (root | (130'd1 << b)) <= s) root = root | (130'd1 << b);
        end
        // Round to nearest: step up when s lies beyond root^2 + root.
        if (s > root * root + root) root = root + 1;
        pr = clamp_q16(1'b0, root);
      end
      default: ;
    endcase
    r.res_re = pr[31:0];
    r.res_im = pi[31:0];
    r.overflow = pr[32] | pi[32];
    return r;
  endfunction

  assign pending_count = result_fifo.size();

  always @(posedge clk) begin
    cplx_result_t want;
    if (!rst_n) begin
      result_fifo.delete();
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        result_fifo.push_back(compute_result(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                             in_tdata[95:64], in_tdata[127:96]));
      if (out_tvalid && out_tready) begin
        if (result_fifo.size() == 0) begin
          $error("result transaction with no input pending: tdata=%h tuser=%b",
                 out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo.pop_front();
          if (want.res_re !== out_tdata[31:0] || want.res_im !== out_tdata[63:32] ||
              want.div_zero !== out_tuser[0] || want.overflow !== out_tuser[1]) begin
            fail_count <= fail_count + 1;
            if (want.res_re !== out_tdata[31:0])
              $error("res_re: expected %h, got %h", want.res_re, out_tdata[31:0]);
            if (want.res_im !== out_tdata[63:32])
              $error("res_im: expected %h, got %h", want.res_im, out_tdata[63:32]);
            if (want.div_zero !== out_tuser[0])
              $error("div_zero: expected %b, got %b", want.div_zero, out_tuser[0]);
            if (want.overflow !== out_tuser[1])
              $error("overflow: expected %b, got %b", want.overflow, out_tuser[1]);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/complex_arithmetic_unit_tb.sv =====
// Testbench top for the complex arithmetic unit: clock, reset, operand stimulus
// and output back-pressure. Depends on cau_pkg, the block and the checker module.
`timescale 1ns / 100ps
`default_nettype none

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  // Added to the final wait once every expected result has been seen.
  localparam int PIPE_LATENCY = 2 * 32 + 16 + 6;
  // Cycles without any transaction before the run is declared hung. It covers
  // the long receiver hold plus a full pipeline flush with generous margin.
  localparam int HANG_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 510;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // a_re, a_im, b_re, b_im from the lowest bit up
  logic [127:0] in_tdata = '0;
  // kind
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // res_re, res_im from the lowest bit up
  logic [63:0]  out_tdata;
  // div_zero, overflow from the lowest bit up
  logic [1:0]   out_tuser;

  int fail_count;
  int pending_count;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int sent_count = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  complex_arithmetic_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  complex_arithmetic_unit_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver side. Once hold_go is raised it refuses results for a long stretch
  // so that the output and skid registers fill and the block stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", HANG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Operand mix: full-range values, with plenty of small numbers, zero,
  // unity and the two extremes so that saturation and exact ties show up.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
      4, 5:    return 32'($signed($urandom_range(262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction and wait until it is taken. The valid line is only
  // lowered during a random idle gap, never between two back-to-back items.
  task automatic offer_operands(input logic [2:0] op, input logic [31:0] ar,
                                input logic [31:0] ai, input logic [31:0] br,
                                input logic [31:0] bi);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {bi, br, ai, ar};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    if (sent_count == 300) hold_go = 1'b1;
  endtask

  initial begin
    logic [2:0] op;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: every operation, saturation both ways, zero divisor,
    // scalar operands, tie rounding and the unused codes.
    offer_operands(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    offer_operands(KIND_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0);
    offer_operands(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    offer_operands(KIND_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
    offer_operands(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer_operands(KIND_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    offer_operands(KIND_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
    offer_operands(KIND_MUL, 32'hffff_ffff, 32'h0, 32'h0000_8000, 32'h0);
    offer_operands(KIND_MUL, 32'h0001_8000, 32'hfffe_0000, 32'h0003_0000, 32'h0);
    offer_operands(KIND_DIV, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0);
    offer_operands(KIND_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    offer_operands(KIND_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h0);
    offer_operands(KIND_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    offer_operands(KIND_DIV, 32'h0005_0000, 32'h0002_0000, 32'h0001_0000, 32'hffff_0000);
    offer_operands(KIND_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    offer_operands(KIND_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    offer_operands(KIND_MAG, 32'h0003_0000, 32'hfffc_0000, 32'h7fff_ffff, 32'h8000_0000);
    offer_operands(KIND_MAG, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
    offer_operands(KIND_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
    offer_operands(3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    offer_operands(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
    offer_operands(3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);

    // Random part in three pacing phases: slow receiver, slow sender, full rate.
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 60 : 0;
      rcv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 30 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        // Scalar second operands appear now and then, as do explicit zero divisors.
        case ($urandom_range(9))
          0:       offer_operands(op, pick_operand(), pick_operand(), pick_operand(), 32'h0);
          1:       offer_operands(op, pick_operand(), pick_operand(), 32'h0, 32'h0);
          default: offer_operands(op, pick_operand(), pick_operand(), pick_operand(),
                                  pick_operand());
        endcase
      end
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 20) @(posedge clk);

    $display("Ran %0d operations (add, subtract, multiply, divide, magnitude, unused codes)",
             sent_count);
    $display("under three pacing mixes and one long output stall; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_cell.sv
rtl/core/cau_final.sv
rtl/core/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_checker.sv
sim/complex_arithmetic_unit_tb.sv
